// ----- rtl/core/irpwbe_pkg.sv -----
package irpwbe_pkg;

  localparam int unsigned MsgWidth     = 48;
  localparam int unsigned MsgRegBytes  = MsgWidth / 8;
  localparam int unsigned MessageBytes = 6;
  localparam int unsigned GapWidth     = 10;
  localparam int unsigned ByteIdxWidth = 3;
  localparam int unsigned BitPosWidth  = 3;
  localparam int unsigned PhaseWidth   = 2;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [MsgWidth-1:0] MessageReset = 48'h6162_6364_6566;
  localparam logic [GapWidth-1:0] GapReset     = 10'd500;
  localparam logic [GapWidth-1:0] FlagReset    = 10'd100;

  localparam logic [ByteIdxWidth-1:0] LastByte = ByteIdxWidth'(MessageBytes - 1);
  localparam logic [BitPosWidth-1:0]  LastBit  = '1;
  localparam logic [PhaseWidth-1:0]   LastPhase = '1;

  // register indexes on the configuration channel
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MESSAGE    = 2'd0,
    REG_GAP_TICKS  = 2'd1,
    REG_FLAG_TICKS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [MsgWidth-1:0] message;
    logic [GapWidth-1:0] gap_ticks;
    logic [GapWidth-1:0] flag_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    carrier_on;
    logic                    indicator_on;
    logic [ByteIdxWidth-1:0] byte_position;
    logic                    in_gap;
  } status_t;

  // one bit of the message; bytes beyond the register read as zero
  function automatic logic msg_bit(logic [MsgWidth-1:0] msg,
                                   logic [ByteIdxWidth-1:0] byte_idx,
                                   logic [BitPosWidth-1:0] bit_pos);
    logic [5:0] idx;
    logic       b;
    idx = 6'(MsgWidth - 1) - {byte_idx, 3'b000} - {3'b000, bit_pos};
    b = 1'b0;
    if ({1'b0, byte_idx} < 4'(MsgRegBytes)) begin
      b = msg[idx];
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/irpwbe_if.sv -----
interface irpwbe_tick_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface irpwbe_result_if;
  logic                                valid;
  logic                                ready;
  logic                                carrier_on;
  logic                                indicator_on;
  logic [irpwbe_pkg::ByteIdxWidth-1:0] byte_position;
  logic                                in_gap;

  modport source (output valid, output carrier_on, output indicator_on,
                  output byte_position, output in_gap, input ready);
  modport sink   (input valid, input carrier_on, input indicator_on,
                  input byte_position, input in_gap, output ready);
endinterface

interface irpwbe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [irpwbe_pkg::CfgIdxWidth-1:0] index;
  logic [irpwbe_pkg::MsgWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/irpwbe_cfg.sv -----
module irpwbe_cfg (
  input  logic                 clk,
  input  logic                 rst,
  irpwbe_cfg_if.sink           cfg,
  output irpwbe_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.message    <= irpwbe_pkg::MessageReset;
      regs.gap_ticks  <= irpwbe_pkg::GapReset;
      regs.flag_ticks <= irpwbe_pkg::FlagReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        irpwbe_pkg::REG_MESSAGE:    regs.message    <= cfg.data;
        irpwbe_pkg::REG_GAP_TICKS:  regs.gap_ticks  <= cfg.data[irpwbe_pkg::GapWidth-1:0];
        irpwbe_pkg::REG_FLAG_TICKS: regs.flag_ticks <= cfg.data[irpwbe_pkg::GapWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/irpwbe_engine.sv -----
module irpwbe_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  irpwbe_pkg::cfg_t       regs,
  input  logic                   step,
  input  logic                   advance,
  output irpwbe_pkg::status_t    status_next
);

  logic [irpwbe_pkg::BitPosWidth-1:0]  bit_position, bit_position_next;
  logic [irpwbe_pkg::PhaseWidth-1:0]   phase_count, phase_count_next;
  logic [irpwbe_pkg::ByteIdxWidth-1:0] byte_index, byte_index_next;
  logic [irpwbe_pkg::GapWidth-1:0]     gap_remaining, gap_remaining_next;
  logic                                carrier_reg, carrier_reg_next;
  logic                                indicator_reg, indicator_reg_next;
  logic [irpwbe_pkg::GapWidth-1:0]     elapsed;
  logic                                cur_bit;

  always_comb begin
    bit_position_next  = bit_position;
    phase_count_next   = phase_count;
    byte_index_next    = byte_index;
    gap_remaining_next = gap_remaining;
    carrier_reg_next   = carrier_reg;
    indicator_reg_next = indicator_reg;
    elapsed            = '0;
    cur_bit = irpwbe_pkg::msg_bit(regs.message, byte_index, bit_position);

    if (advance) begin
      if (gap_remaining != '0) begin
        // gap shortened below what remains: treat as just started
        if (regs.gap_ticks >= gap_remaining) begin
          elapsed = regs.gap_ticks - gap_remaining;
        end
        indicator_reg_next = (elapsed < regs.flag_ticks);
        gap_remaining_next = gap_remaining - 1'b1;
      end else begin
        carrier_reg_next = cur_bit ? (phase_count != irpwbe_pkg::LastPhase)
                                   : (phase_count == '0);
        if (phase_count == irpwbe_pkg::LastPhase) begin
          phase_count_next = '0;
          if (bit_position == irpwbe_pkg::LastBit) begin
            bit_position_next  = '0;
            gap_remaining_next = regs.gap_ticks;
            byte_index_next    = (byte_index == irpwbe_pkg::LastByte) ? '0
                                                                      : byte_index + 1'b1;
          end else begin
            bit_position_next = bit_position + 1'b1;
          end
        end else begin
          phase_count_next = phase_count + 1'b1;
        end
      end
    end

    status_next.carrier_on    = carrier_reg_next;
    status_next.indicator_on  = indicator_reg_next;
    status_next.byte_position = byte_index_next;
    status_next.in_gap        = (gap_remaining_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      phase_count   <= '0;
      byte_index    <= '0;
      gap_remaining <= '0;
      carrier_reg   <= 1'b0;
      indicator_reg <= 1'b0;
    end else if (step) begin
      bit_position  <= bit_position_next;
      phase_count   <= phase_count_next;
      byte_index    <= byte_index_next;
      gap_remaining <= gap_remaining_next;
      carrier_reg   <= carrier_reg_next;
      indicator_reg <= indicator_reg_next;
    end
  end

endmodule

// ----- rtl/core/ir_pulse_width_beacon_encoder_top.sv -----
// Infrared pulse-width beacon encoder.
// tick channel: one request per bit-timer event; advance = 1 moves the beacon
//   on by one tick, advance = 0 only reports the current outputs.
// result channel: exactly one result per request, after the update: carrier
//   enable, gap indicator, byte being sent and the in-gap flag.
// cfg channel: index 0 message (first byte in the top eight bits), 1 gap
//   length in ticks, 2 indicator length in ticks. Always ready; write only
//   while no result is outstanding.
// Output timing: the result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are read; the only storage
//   on the path is the result register, which is refilled in the cycle it is taken.
// Stall: while a result waits unread, tick.ready is low and no state moves.
// Reset (rst, synchronous): registers take their defaults (message "abcdef",
//   gap 500, indicator 100), beacon state clears to the first bit of byte 0,
//   and the result register empties.
module ir_pulse_width_beacon_encoder_top (
  input  logic         clk,
  input  logic         rst,
  irpwbe_tick_if.sink  tick,
  irpwbe_result_if.source result,
  irpwbe_cfg_if.sink   cfg
);

  irpwbe_pkg::cfg_t    regs;
  irpwbe_pkg::status_t status_next;
  irpwbe_pkg::status_t status;
  logic                out_valid;
  logic                accept;

  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  irpwbe_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  irpwbe_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .step        (accept),
    .advance     (tick.advance),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.carrier_on    = status.carrier_on;
  assign result.indicator_on  = status.indicator_on;
  assign result.byte_position = status.byte_position;
  assign result.in_gap        = status.in_gap;

endmodule
